/* hdl/slip_pkg.sv */
// shared constants and types for the slip frame decoder
package slip_pkg;

    // framing byte codes
    localparam logic [7:0] BYTE_FLAG     = 8'hC0;
    localparam logic [7:0] BYTE_ESC      = 8'hDB;
    localparam logic [7:0] BYTE_ESC_FLAG = 8'hDC;
    localparam logic [7:0] BYTE_ESC_ESC  = 8'hDD;

    // field widths
    localparam int LEN_W = 13;
    localparam int CNT_W = 32;
    localparam int APB_W = 32;
    localparam int ADDR_W = 3;

    // register map, word index
    typedef enum logic [0:0] {
        REG_MAX_PAYLOAD = 1'b0
    } t_reg_idx;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 13'd552;

endpackage

/* hdl/slip_frame_decoder.sv */
// slip receive deframer with apb configuration and registered result
// an accepted word shows its result on the outputs in the next cycle
// one word per cycle unless the sink stalls; result reg reloads in the cycle it is taken
// the ready output is low only while a result waits and the sink stalls
// reset is synchronous, active low: escape flag, fill count, both counters and valid clear,
// max_payload returns to 552
module slip_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_rx_byte,
    input  logic                          i_buffer_available,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_data_valid,
    output logic [7:0]                    o_data_byte,
    output logic                          o_frame_end,
    output logic [slip_pkg::LEN_W-1:0]    o_frame_length,
    output logic                          o_frame_abort,
    output logic [slip_pkg::CNT_W-1:0]    o_byte_total,
    output logic [slip_pkg::CNT_W-1:0]    o_overflow_total,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slip_pkg::ADDR_W-1:0]   paddr,
    input  logic [slip_pkg::APB_W-1:0]    pwdata,
    output logic [slip_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import slip_pkg::*;

    logic [LEN_W-1:0]   r_max_payload;
    logic               r_escape;
    logic [LEN_W-1:0]   r_fill_count;
    logic [CNT_W-1:0]   r_accepted_bytes;
    logic [CNT_W-1:0]   r_overflow_count;

    logic               r_out_valid;
    logic               r_data_valid;
    logic [7:0]         r_data_byte;
    logic               r_frame_end;
    logic [LEN_W-1:0]   r_frame_length;
    logic               r_frame_abort;

    logic               n_escape;
    logic [LEN_W-1:0]   n_fill_count;
    logic [CNT_W-1:0]   n_accepted_bytes;
    logic [CNT_W-1:0]   n_overflow_count;
    logic               n_data_valid;
    logic [7:0]         n_data_byte;
    logic               n_frame_end;
    logic [LEN_W-1:0]   n_frame_length;
    logic               n_frame_abort;

    logic               acc;
    logic               cfg_wr;
    logic               max_payload_wr;
    t_reg_idx           reg_idx;
    logic [7:0]         unesc_byte;

    // handshake
    assign o_ready = !r_out_valid || i_ready;
    assign acc     = i_valid && o_ready;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign max_payload_wr = cfg_wr && (reg_idx == REG_MAX_PAYLOAD);

    always_comb begin
        case (reg_idx)
            REG_MAX_PAYLOAD: prdata = {{(APB_W-LEN_W){1'b0}}, r_max_payload};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (max_payload_wr) begin
            r_max_payload <= pwdata[LEN_W-1:0];
        end
    end

    // unescape the received byte
    always_comb begin
        unesc_byte = i_rx_byte;
        if (r_escape) begin
            if (i_rx_byte == BYTE_ESC_FLAG) begin
                unesc_byte = BYTE_FLAG;
            end else if (i_rx_byte == BYTE_ESC_ESC) begin
                unesc_byte = BYTE_ESC;
            end
        end
    end

    // deframing decision and next state
    always_comb begin
        n_escape         = r_escape;
        n_fill_count     = r_fill_count;
        n_accepted_bytes = r_accepted_bytes;
        n_overflow_count = r_overflow_count;
        n_data_valid     = 1'b0;
        n_data_byte      = '0;
        n_frame_end      = 1'b0;
        n_frame_length   = '0;
        n_frame_abort    = 1'b0;
        if (i_buffer_available) begin
            if (i_rx_byte == BYTE_FLAG) begin
                n_escape = 1'b0;
                if (r_fill_count != '0) begin
                    n_frame_end    = 1'b1;
                    n_frame_length = r_fill_count;
                    n_fill_count   = '0;
                end
            end else if (i_rx_byte == BYTE_ESC) begin
                n_escape = 1'b1;
            end else begin
                n_escape = 1'b0;
                if (r_fill_count >= r_max_payload) begin
                    n_frame_abort    = 1'b1;
                    n_fill_count     = '0;
                    n_overflow_count = r_overflow_count + 1'b1;
                end else begin
                    n_data_valid     = 1'b1;
                    n_data_byte      = unesc_byte;
                    n_fill_count     = r_fill_count + 1'b1;
                    n_accepted_bytes = r_accepted_bytes + 1'b1;
                end
            end
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape         <= 1'b0;
            r_fill_count     <= '0;
            r_accepted_bytes <= '0;
            r_overflow_count <= '0;
        end else if (acc) begin
            r_escape         <= n_escape;
            r_fill_count     <= n_fill_count;
            r_accepted_bytes <= n_accepted_bytes;
            r_overflow_count <= n_overflow_count;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_data_valid   <= n_data_valid;
            r_data_byte    <= n_data_byte;
            r_frame_end    <= n_frame_end;
            r_frame_length <= n_frame_length;
            r_frame_abort  <= n_frame_abort;
        end
    end

    // outputs; the counters only move on accept, which needs any held result word taken
    assign o_valid          = r_out_valid;
    assign o_data_valid     = r_data_valid;
    assign o_data_byte      = r_data_byte;
    assign o_frame_end      = r_frame_end;
    assign o_frame_length   = r_frame_length;
    assign o_frame_abort    = r_frame_abort;
    assign o_byte_total     = r_accepted_bytes;
    assign o_overflow_total = r_overflow_count;

    // at most one event kind per result word
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0({r_data_valid, r_frame_end, r_frame_abort}))
        else $error("more than one event in a result word");

    // a closed frame always has a nonzero length
    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_frame_end |-> r_frame_length != '0)
        else $error("frame end with zero length");

    // overflow counter moves by one exactly on an abort
    a_ovf_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_overflow_count == $past(r_overflow_count)
                                    + {{(CNT_W-1){1'b0}}, r_frame_abort})
        else $error("overflow count out of step with abort");

    // a passed payload byte grows the frame and the byte count by one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && n_data_valid |=> r_fill_count == $past(r_fill_count) + 1'b1 &&
                                r_accepted_bytes == $past(r_accepted_bytes) + 1'b1)
        else $error("fill or byte count out of step");

    // without an accepted word the decoder state holds
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_fill_count) && $stable(r_escape) &&
                 $stable(r_accepted_bytes) && $stable(r_overflow_count))
        else $error("decoder state moved without a word");

endmodule

/* tb/tb_slip_frame_decoder.sv */
// testbench for slip_frame_decoder: byte stream stimulus, deframing predictor and result checks
`timescale 1ns / 100ps

module tb_slip_frame_decoder;

    import slip_pkg::*;

    // the watchdog fails the run after this many cycles with no handshake at all;
    // the longest legal quiet stretch is the receiver hold plus a long gap
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_WORDS = 160;

    // one decoded result, field for field as the block reports it
    typedef struct packed {
        logic              data_valid;
        logic [7:0]        data_byte;
        logic              frame_end;
        logic [LEN_W-1:0]  frame_length;
        logic              frame_abort;
        logic [CNT_W-1:0]  byte_total;
        logic [CNT_W-1:0]  overflow_total;
    } t_decoded;

    // deframer state mirror and queue of decoded results still owed by the block
    class t_deframe_tracker;
        logic [LEN_W-1:0] max_payload;
        logic             escape_armed;
        logic [LEN_W-1:0] fill;
        logic [CNT_W-1:0] bytes_in;
        logic [CNT_W-1:0] drops;
        t_decoded         decoded_q[$];
        int unsigned      mismatches;

        function new();
            max_payload  = MAX_PAYLOAD_RESET;
            escape_armed = 1'b0;
            fill         = '0;
            bytes_in     = '0;
            drops        = '0;
            mismatches   = 0;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        // unframe one accepted word and queue the result it must produce
        function void note_word(logic [7:0] rx, logic avail);
            t_decoded   r;
            logic [7:0] b;
            r = '0;
            b = rx;
            if (avail) begin
                if (b == BYTE_FLAG) begin
                    escape_armed = 1'b0;
                    if (fill != 0) begin
                        r.frame_end    = 1'b1;
                        r.frame_length = fill;
                        fill           = '0;
                    end
                end else if (b == BYTE_ESC) begin
                    escape_armed = 1'b1;
                end else begin
                    if (escape_armed) begin
                        escape_armed = 1'b0;
                        if (b == BYTE_ESC_FLAG) begin
                            b = BYTE_FLAG;
                        end else if (b == BYTE_ESC_ESC) begin
                            b = BYTE_ESC;
                        end
                    end
                    if (fill >= max_payload) begin
                        r.frame_abort = 1'b1;
                        fill          = '0;
                        drops         = drops + 1'b1;
                    end else begin
                        r.data_valid = 1'b1;
                        r.data_byte  = b;
                        fill         = fill + 1'b1;
                        bytes_in     = bytes_in + 1'b1;
                    end
                end
            end
            r.byte_total     = bytes_in;
            r.overflow_total = drops;
            decoded_q.push_back(r);
        endfunction

        // compare one taken result against the oldest owed one
        function void check_result(t_decoded got);
            t_decoded want;
            if (decoded_q.size() == 0) begin
                flag_error("result with no word pending");
                return;
            end
            want = decoded_q.pop_front();
            if (got.data_valid !== want.data_valid)
                flag_error($sformatf("data_valid expected %0h got %0h",
                                     want.data_valid, got.data_valid));
            if (got.data_byte !== want.data_byte)
                flag_error($sformatf("data_byte expected %0h got %0h",
                                     want.data_byte, got.data_byte));
            if (got.frame_end !== want.frame_end)
                flag_error($sformatf("frame_end expected %0h got %0h",
                                     want.frame_end, got.frame_end));
            if (got.frame_length !== want.frame_length)
                flag_error($sformatf("frame_length expected %0d got %0d",
                                     want.frame_length, got.frame_length));
            if (got.frame_abort !== want.frame_abort)
                flag_error($sformatf("frame_abort expected %0h got %0h",
                                     want.frame_abort, got.frame_abort));
            if (got.byte_total !== want.byte_total)
                flag_error($sformatf("byte_total expected %0d got %0d",
                                     want.byte_total, got.byte_total));
            if (got.overflow_total !== want.overflow_total)
                flag_error($sformatf("overflow_total expected %0d got %0d",
                                     want.overflow_total, got.overflow_total));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [7:0]        i_rx_byte;
    logic              i_buffer_available;
    logic              o_valid;
    logic              i_ready;
    logic              o_data_valid;
    logic [7:0]        o_data_byte;
    logic              o_frame_end;
    logic [LEN_W-1:0]  o_frame_length;
    logic              o_frame_abort;
    logic [CNT_W-1:0]  o_byte_total;
    logic [CNT_W-1:0]  o_overflow_total;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    t_deframe_tracker    tracker = new();
    int unsigned         words_sent = 0;
    bit                  calm = 1'b0;
    bit                  hold_rx = 1'b0;
    int unsigned         quiet_cycles = 0;

    slip_frame_decoder u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_rx_byte          (i_rx_byte),
        .i_buffer_available (i_buffer_available),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_data_valid       (o_data_valid),
        .o_data_byte        (o_data_byte),
        .o_frame_end        (o_frame_end),
        .o_frame_length     (o_frame_length),
        .o_frame_abort      (o_frame_abort),
        .o_byte_total       (o_byte_total),
        .o_overflow_total   (o_overflow_total),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // payload length, mostly short, sometimes right around the limit, capped at 60
    function automatic int unsigned frame_len(int unsigned limit);
        int unsigned hi;
        hi = (limit < 60) ? limit + 3 : 60;
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, (hi < 12) ? hi : 12);
        return $urandom_range((hi > 4) ? hi - 4 : 0, hi);
    endfunction

    // offer one word, hold it until taken, then maybe go idle
    task automatic send_word(input logic [7:0] b, input logic avail);
        int unsigned gap;
        i_valid            <= 1'b1;
        i_rx_byte          <= b;
        i_buffer_available <= avail;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_word(b, avail);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // well formed frame: escaped random payload closed by a flag
    task automatic send_frame(input int unsigned len);
        logic [7:0] b;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: b = BYTE_FLAG;
                    1: b = BYTE_ESC;
                    2: b = BYTE_ESC_FLAG;
                    default: b = BYTE_ESC_ESC;
                endcase
            end else begin
                b = 8'($urandom());
            end
            // occasional word while no buffer is available
            if ($urandom_range(0, 24) == 0) send_word(8'($urandom()), 1'b0);
            if (b == BYTE_FLAG) begin
                send_word(BYTE_ESC, 1'b1);
                send_word(BYTE_ESC_FLAG, 1'b1);
            end else if (b == BYTE_ESC) begin
                send_word(BYTE_ESC, 1'b1);
                send_word(BYTE_ESC_ESC, 1'b1);
            end else begin
                send_word(b, 1'b1);
            end
        end
        send_word(BYTE_FLAG, 1'b1);
    endtask

    // broken sequences: stray escapes, flags and raw codes
    task automatic send_noise(input int unsigned n);
        logic [7:0] b;
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: b = BYTE_FLAG;
                1: b = BYTE_ESC;
                2: b = BYTE_ESC_FLAG;
                3: b = BYTE_ESC_ESC;
                default: b = 8'($urandom());
            endcase
            send_word(b, $urandom_range(0, 5) != 0);
        end
    endtask

    task automatic run_traffic(input int unsigned n_words);
        int unsigned stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                send_frame(frame_len(tracker.max_payload));
            end else begin
                send_noise($urandom_range(1, 6));
            end
        end
    endtask

    // stop offering and wait until every owed result has come back
    task automatic drain_results(input int unsigned extra);
        i_valid <= 1'b0;
        while (tracker.decoded_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read the limit back and compare with the mirrored value
    task automatic check_max_payload();
        logic [APB_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(REG_MAX_PAYLOAD) << 2;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_W'(tracker.max_payload))
            tracker.flag_error($sformatf("max_payload readback expected %0d got %0d",
                                         tracker.max_payload, got));
    endtask

    task automatic set_max_payload(input int unsigned limit);
        drain_results(4);
        apb_write(REG_MAX_PAYLOAD, APB_W'(limit));
        tracker.max_payload = LEN_W'(limit);
        check_max_payload();
    endtask

    // result side: check taken words, stall at random, honor the long hold
    initial begin
        int unsigned stall_left;
        t_decoded    got;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.data_valid     = o_data_valid;
                got.data_byte      = o_data_byte;
                got.frame_end      = o_frame_end;
                got.frame_length   = o_frame_length;
                got.frame_abort    = o_frame_abort;
                got.byte_total     = o_byte_total;
                got.overflow_total = o_overflow_total;
                tracker.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (hold_rx) begin
                hold_rx = 1'b0;
                stall_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                i_ready <= (stall_left == 0);
            end
        end
    end

    // watchdog on cycles with no handshake on any port
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("slip_frame_decoder regression: fail");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        int unsigned phase_limit[8];
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_rx_byte          <= '0;
        i_buffer_available <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_max_payload();

        // directed walk at the reset limit
        send_word(BYTE_FLAG, 1'b1);       // empty frame
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(BYTE_ESC, 1'b1);
        send_word(BYTE_ESC_FLAG, 1'b1);   // escaped flag
        send_word(BYTE_ESC, 1'b1);
        send_word(BYTE_ESC_ESC, 1'b1);    // escaped escape
        send_word(BYTE_ESC, 1'b1);
        send_word(8'h5A, 1'b1);           // other escaped byte passes
        send_word(8'h33, 1'b0);           // no buffer
        send_word(BYTE_ESC, 1'b1);
        send_word(BYTE_FLAG, 1'b0);       // ignored, escape stays armed
        send_word(BYTE_ESC_FLAG, 1'b1);
        send_word(BYTE_ESC, 1'b1);
        send_word(BYTE_FLAG, 1'b1);       // flag after escape still closes
        send_word(BYTE_FLAG, 1'b1);

        // overflow at the smallest limit
        set_max_payload(1);
        send_word(8'h10, 1'b1);
        send_word(8'h11, 1'b1);           // drops the frame
        send_word(8'h12, 1'b1);
        send_word(BYTE_FLAG, 1'b1);
        send_word(BYTE_ESC, 1'b1);
        send_word(BYTE_ESC_ESC, 1'b1);
        send_word(BYTE_ESC, 1'b1);
        send_word(BYTE_ESC_FLAG, 1'b1);   // escaped byte overflows

        // a limit of 4096 with one long frame
        set_max_payload(4096);
        send_frame(200);

        // random phases over several limits
        phase_limit = '{2, 3, 552, 7, 1, 4096, $urandom_range(1, 64), 33};
        foreach (phase_limit[p]) begin
            set_max_payload(phase_limit[p]);
            calm = (p == 3) || (p == 5);
            if (p == 5) hold_rx = 1'b1;
            run_traffic(PHASE_WORDS);
        end
        calm = 1'b0;

        drain_results(8);
        if (tracker.mismatches == 0) begin
            $display("slip_frame_decoder regression: pass");
        end else begin
            $display("slip_frame_decoder regression: fail");
        end
        $finish;
    end

endmodule
